/* rtl/core/arcf_pkg.sv */
// Shared constants and codes for the alignment row coverage filter.
// Depends on nothing; the top level refers to it by scoped names.
package arcf_pkg;

    localparam int FIELD_W = 13;
    localparam int PCT_W   = 7;
    localparam int IDX_W   = 1;

    localparam logic [7:0] GAP_CHAR = 8'h2D;
    localparam logic [7:0] LOWER_A  = 8'h61;
    localparam logic [7:0] LOWER_Z  = 8'h7A;

    localparam logic [PCT_W-1:0] PCT_SCALE        = 7'd100;
    localparam logic [PCT_W-1:0] MIN_COVERAGE_RST = 7'd75;
    localparam logic [PCT_W-1:0] MIN_IDENTITY_RST = 7'd15;

    typedef enum logic [IDX_W-1:0] {
        REG_MIN_COVERAGE = 1'b0,
        REG_MIN_IDENTITY = 1'b1
    } cfg_reg_t;

endpackage

/* rtl/core/alignment_row_coverage_filter.sv */
// Alignment row coverage / identity filter, top level.
// Holds the query column store, the row counters and the result register.
// Depends on arcf_pkg.
//
// One character is taken every cycle while item_stall is low, with no bubbles
// between rows. The edge that takes a character updates the column and gap
// counters, reads the query store at the character's column and loads the
// scoring stage, which scores the match and, for a row's last character,
// loads the result register. The query store has one write and one read
// port, both used at the edge that takes a character; it is not cleared, so a
// candidate must follow a query row that covers its columns. Stall on the
// result side holds the scoring stage and, through it, the character input.
module alignment_row_coverage_filter #(
    parameter int MAX_COLUMNS = 4096
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [arcf_pkg::IDX_W-1:0]      cfg_index,
    input  logic [arcf_pkg::PCT_W-1:0]      cfg_data,
    input  logic                            item_valid,
    output logic                            item_stall,
    input  logic                            cmd,
    input  logic [7:0]                      ch,
    input  logic                            row_end,
    input  logic                            has_id,
    output logic                            result_valid,
    input  logic                            result_stall,
    output logic                            keep,
    output logic                            row_is_query,
    output logic [arcf_pkg::FIELD_W-1:0]    gap_count,
    output logic [arcf_pkg::FIELD_W-1:0]    match_count,
    output logic [arcf_pkg::FIELD_W-1:0]    row_length,
    output logic                            too_long
);

    localparam int CW = $clog2(MAX_COLUMNS + 1);
    localparam int AW = $clog2(MAX_COLUMNS);
    localparam int PW = CW + arcf_pkg::PCT_W;

    logic [arcf_pkg::PCT_W-1:0] min_cov_reg;
    logic [arcf_pkg::PCT_W-1:0] min_id_reg;

    logic [7:0] query_mem [MAX_COLUMNS];
    logic [7:0] rdata_reg;

    logic [CW-1:0] col_reg, col_next;
    logic [CW-1:0] gap_reg, gap_next;
    logic          ovf_reg, ovf_next;
    logic [CW-1:0] qlen_reg;
    logic          qovf_reg;

    logic          is_lower, counted, ovf_hit, col_ok, is_gap;
    logic [CW-1:0] col_item, gap_item;
    logic          ovf_item;
    logic          accept, s1_go, s1_fire;

    logic          s1_valid_reg, s1_valid_next;
    logic          s1_cand_reg;
    logic [7:0]    s1_ch_reg;
    logic          s1_row_end_reg;
    logic          s1_has_id_reg;
    logic          s1_try_reg;
    logic          s1_lt_q_reg;
    logic [CW-1:0] s1_len_reg;
    logic [CW-1:0] s1_gaps_reg;
    logic          s1_ovf_reg;
    logic          s1_qovf_reg;
    logic          s1_qlen_nz_reg;
    logic          s1_len_eq_reg;

    logic [CW-1:0] match_reg, match_next;
    logic          m_inc;
    logic [CW-1:0] match_item;
    logic [PW-1:0] cov_lhs, cov_rhs, id_lhs, id_rhs;
    logic          cand_keep;

    logic                         out_load;
    logic                         result_valid_reg, result_valid_next;
    logic                         keep_reg, row_is_query_reg, too_long_reg;
    logic [arcf_pkg::FIELD_W-1:0] gap_count_reg, match_count_reg, row_length_reg;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_cov_reg <= arcf_pkg::MIN_COVERAGE_RST;
            min_id_reg  <= arcf_pkg::MIN_IDENTITY_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                arcf_pkg::REG_MIN_COVERAGE: min_cov_reg <= cfg_data;
                arcf_pkg::REG_MIN_IDENTITY: min_id_reg  <= cfg_data;
                default:                    min_cov_reg <= min_cov_reg;
            endcase
        end
    end

    // Handshake
    assign s1_go      = !(s1_valid_reg && s1_row_end_reg && result_valid_reg && result_stall);
    assign item_stall = !s1_go;
    assign accept     = item_valid && s1_go;
    assign s1_fire    = s1_valid_reg && s1_go;

    // Column classification and counters
    assign is_lower = (ch >= arcf_pkg::LOWER_A) && (ch <= arcf_pkg::LOWER_Z);
    assign counted  = !is_lower;
    assign ovf_hit  = counted && (col_reg >= CW'(MAX_COLUMNS));
    assign col_ok   = counted && !ovf_hit;
    assign is_gap   = (ch == arcf_pkg::GAP_CHAR);

    assign col_item = col_reg + CW'(col_ok);
    assign gap_item = gap_reg + CW'(col_ok && is_gap);
    assign ovf_item = ovf_reg || ovf_hit;

    always_comb
    begin
        col_next = col_reg;
        gap_next = gap_reg;
        ovf_next = ovf_reg;
        if (accept)
        begin
            if (row_end)
            begin
                col_next = '0;
                gap_next = '0;
                ovf_next = 1'b0;
            end
            else
            begin
                col_next = col_item;
                gap_next = gap_item;
                ovf_next = ovf_item;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            gap_reg  <= '0;
            ovf_reg  <= 1'b0;
            qlen_reg <= '0;
            qovf_reg <= 1'b0;
        end
        else
        begin
            col_reg <= col_next;
            gap_reg <= gap_next;
            ovf_reg <= ovf_next;
            if (accept && row_end && !cmd)
            begin
                qlen_reg <= col_item;
                qovf_reg <= ovf_item;
            end
        end
    end

    // Query column store
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            if (!cmd && col_ok)
            begin
                query_mem[col_reg[AW-1:0]] <= ch;
            end
            rdata_reg <= query_mem[col_reg[AW-1:0]];
        end
    end

    // Scoring stage
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_cand_reg    <= cmd;
            s1_ch_reg      <= ch;
            s1_row_end_reg <= row_end;
            s1_has_id_reg  <= has_id;
            s1_try_reg     <= col_ok && !is_gap;
            s1_lt_q_reg    <= col_reg < qlen_reg;
            s1_len_reg     <= col_item;
            s1_gaps_reg    <= gap_item;
            s1_ovf_reg     <= ovf_item;
            s1_qovf_reg    <= qovf_reg;
            s1_qlen_nz_reg <= qlen_reg != '0;
            s1_len_eq_reg  <= col_item == qlen_reg;
        end
    end

    assign m_inc = s1_try_reg &&
                   (!s1_cand_reg || (s1_lt_q_reg && (rdata_reg == s1_ch_reg)));
    assign match_item = match_reg + CW'(m_inc);

    always_comb
    begin
        match_next = match_reg;
        if (s1_fire)
        begin
            match_next = s1_row_end_reg ? '0 : match_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= '0;
        end
        else
        begin
            match_reg <= match_next;
        end
    end

    assign cov_lhs = PW'(s1_len_reg - s1_gaps_reg) * PW'(arcf_pkg::PCT_SCALE);
    assign cov_rhs = PW'(min_cov_reg) * PW'(s1_len_reg);
    assign id_lhs  = PW'(match_item) * PW'(arcf_pkg::PCT_SCALE);
    assign id_rhs  = PW'(min_id_reg) * PW'(s1_len_reg);

    assign cand_keep = s1_has_id_reg && !s1_ovf_reg && !s1_qovf_reg && s1_qlen_nz_reg &&
                       s1_len_eq_reg && (cov_lhs >= cov_rhs) && (id_lhs >= id_rhs);

    // Result register
    assign out_load = s1_valid_reg && s1_row_end_reg && !(result_valid_reg && result_stall);

    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (out_load)
        begin
            result_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            keep_reg         <= !s1_cand_reg || cand_keep;
            row_is_query_reg <= !s1_cand_reg;
            gap_count_reg    <= arcf_pkg::FIELD_W'(s1_gaps_reg);
            match_count_reg  <= arcf_pkg::FIELD_W'(match_item);
            row_length_reg   <= arcf_pkg::FIELD_W'(s1_len_reg);
            too_long_reg     <= s1_ovf_reg;
        end
    end

    assign result_valid = result_valid_reg;
    assign keep         = keep_reg;
    assign row_is_query = row_is_query_reg;
    assign gap_count    = gap_count_reg;
    assign match_count  = match_count_reg;
    assign row_length   = row_length_reg;
    assign too_long     = too_long_reg;

`ifndef ASSERT_OFF
    a_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
        col_reg <= CW'(MAX_COLUMNS))
        else $error("column counter beyond store capacity");

    a_row_clear: assert property (@(posedge clk) disable iff (!rst_n)
        accept && row_end |=> col_reg == '0 && gap_reg == '0 && !ovf_reg)
        else $error("row counters not cleared after row end");

    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> $past(s1_valid_reg && s1_row_end_reg))
        else $error("result without a closing character");

    a_query_kept: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && row_is_query_reg |-> keep_reg)
        else $error("query row not kept");

    a_long_reject: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && !row_is_query_reg && keep_reg |-> !too_long_reg)
        else $error("too-long candidate kept");
`endif

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench for alignment_row_coverage_filter.
// Drives character streams, predicts each row verdict and compares it with the DUT output.
// Depends on arcf_pkg and the filter RTL.
module tb_top;

    localparam int MAX_COLS       = 4096;
    localparam int LONG_COLS      = 96;
    localparam int SETTLE_CYCLES  = 8;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int RANDOM_ITEMS   = 1400;
    localparam int RANDOM_PHASES  = 8;

    localparam logic CMD_QUERY = 1'b0;
    localparam logic CMD_CAND  = 1'b1;

    typedef struct packed {
        logic       cmd;
        logic [7:0] ch;
        logic       row_end;
        logic       has_id;
    } char_item_t;

    typedef struct packed {
        logic                         keep;
        logic                         row_is_query;
        logic [arcf_pkg::FIELD_W-1:0] gaps;
        logic [arcf_pkg::FIELD_W-1:0] hits;
        logic [arcf_pkg::FIELD_W-1:0] length;
        logic                         too_long;
    } row_verdict_t;

    typedef logic [7:0] byte_q_t[$];

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         cfg_we = 1'b0;
    logic [arcf_pkg::IDX_W-1:0]   cfg_index = '0;
    logic [arcf_pkg::PCT_W-1:0]   cfg_data = '0;
    logic                         item_valid = 1'b0;
    logic                         item_stall;
    logic                         cmd = 1'b0;
    logic [7:0]                   ch = 8'h00;
    logic                         row_end = 1'b0;
    logic                         has_id = 1'b0;
    logic                         result_valid;
    logic                         result_stall = 1'b0;
    logic                         keep;
    logic                         row_is_query;
    logic [arcf_pkg::FIELD_W-1:0] gap_count;
    logic [arcf_pkg::FIELD_W-1:0] match_count;
    logic [arcf_pkg::FIELD_W-1:0] row_length;
    logic                         too_long;

    alignment_row_coverage_filter #(
        .MAX_COLUMNS(MAX_COLS)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .item_valid  (item_valid),
        .item_stall  (item_stall),
        .cmd         (cmd),
        .ch          (ch),
        .row_end     (row_end),
        .has_id      (has_id),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .keep        (keep),
        .row_is_query(row_is_query),
        .gap_count   (gap_count),
        .match_count (match_count),
        .row_length  (row_length),
        .too_long    (too_long)
    );

    always #2 clk = ~clk;

    // Scoring state mirrored from the filter's behavior.
    logic [7:0]               query_cols [MAX_COLS];
    int unsigned              qry_len = 0;
    int unsigned              col_idx = 0;
    int unsigned              gap_cnt = 0;
    int unsigned              match_cnt = 0;
    bit                       ovf_seen = 1'b0;
    bit                       qry_ovf = 1'b0;
    logic [arcf_pkg::PCT_W-1:0] cov_pct = arcf_pkg::MIN_COVERAGE_RST;
    logic [arcf_pkg::PCT_W-1:0] id_pct = arcf_pkg::MIN_IDENTITY_RST;

    row_verdict_t expected_verdicts[$];
    row_verdict_t want;

    int  errors = 0;
    int  chars_sent = 0;
    int  rows_checked = 0;
    int  rows_kept = 0;
    int  rows_too_long = 0;
    int  idle_cycles = 0;
    bit  tx_idle_en = 1'b1;
    bit  rx_idle_en = 1'b1;
    int  hold_requests = 0;
    int  hold_served = 0;
    int  hold_left = 0;
    int  burst_left = 0;

    function automatic bit is_lower(input logic [7:0] b);
        return b >= arcf_pkg::LOWER_A && b <= arcf_pkg::LOWER_Z;
    endfunction

    function automatic logic [7:0] rand_lower();
        return arcf_pkg::LOWER_A + 8'($urandom_range(0, 25));
    endfunction

    function automatic logic [7:0] rand_column_byte();
        logic [7:0] b;
        case ($urandom_range(0, 9))
            0: b = arcf_pkg::GAP_CHAR;
            1, 2, 3, 4: b = 8'h41 + 8'($urandom_range(0, 25));
            default:
            begin
                b = 8'($urandom_range(0, 255));
                if (is_lower(b))
                    b = b ^ 8'h20;
            end
        endcase
        return b;
    endfunction

    function automatic logic [7:0] candidate_byte(input int unsigned col);
        int pick;
        pick = $urandom_range(0, 99);
        if (col < qry_len && pick < 60)
            return query_cols[col];
        if (pick < 75)
            return arcf_pkg::GAP_CHAR;
        return rand_column_byte();
    endfunction

    task automatic score_char(input char_item_t it);
        row_verdict_t v;
        int unsigned  len;
        bit           ok;
        if (!is_lower(it.ch))
        begin
            if (col_idx >= MAX_COLS)
                ovf_seen = 1'b1;
            else
            begin
                if (it.ch == arcf_pkg::GAP_CHAR)
                    gap_cnt++;
                else if (it.cmd == CMD_QUERY)
                    match_cnt++;
                else if (col_idx < qry_len && query_cols[col_idx] == it.ch)
                    match_cnt++;
                if (it.cmd == CMD_QUERY)
                    query_cols[col_idx] = it.ch;
                col_idx++;
            end
        end
        if (it.row_end)
        begin
            len = col_idx;
            if (it.cmd == CMD_QUERY)
            begin
                ok = 1'b1;
                qry_len = col_idx;
                qry_ovf = ovf_seen;
            end
            else
            begin
                ok = it.has_id && !ovf_seen && !qry_ovf && qry_len != 0 && col_idx == qry_len
                     && arcf_pkg::PCT_SCALE * (len - gap_cnt) >= cov_pct * len
                     && arcf_pkg::PCT_SCALE * match_cnt >= id_pct * len;
            end
            v.keep         = ok;
            v.row_is_query = (it.cmd == CMD_QUERY);
            v.gaps         = gap_cnt[arcf_pkg::FIELD_W-1:0];
            v.hits         = match_cnt[arcf_pkg::FIELD_W-1:0];
            v.length       = col_idx[arcf_pkg::FIELD_W-1:0];
            v.too_long     = ovf_seen;
            expected_verdicts = {expected_verdicts, v};
            col_idx   = 0;
            gap_cnt   = 0;
            match_cnt = 0;
            ovf_seen  = 1'b0;
        end
    endtask

    task automatic send_item(input char_item_t it);
        int gap;
        gap = 0;
        if (tx_idle_en && $urandom_range(0, 7) == 0)
            gap = $urandom_range(1, 15);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        cmd        <= it.cmd;
        ch         <= it.ch;
        row_end    <= it.row_end;
        has_id     <= it.has_id;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        score_char(it);
        chars_sent++;
    endtask

    task automatic send_row(input logic c, input logic id, input byte_q_t bytes);
        char_item_t it;
        foreach (bytes[i])
        begin
            it.cmd     = c;
            it.ch      = bytes[i];
            it.row_end = (i == bytes.size() - 1);
            it.has_id  = id;
            send_item(it);
        end
    endtask

    task automatic drain();
        item_valid <= 1'b0;
        @(posedge clk);
        while (expected_verdicts.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_thresholds(input logic [arcf_pkg::PCT_W-1:0] cov,
                                  input logic [arcf_pkg::PCT_W-1:0] ident);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= arcf_pkg::REG_MIN_COVERAGE;
        cfg_data  <= cov;
        @(posedge clk);
        cfg_index <= arcf_pkg::REG_MIN_IDENTITY;
        cfg_data  <= ident;
        @(posedge clk);
        cfg_we <= 1'b0;
        cov_pct = cov;
        id_pct  = ident;
        @(posedge clk);
    endtask

    task automatic random_row();
        byte_q_t    bytes;
        char_item_t it;
        int         kind;
        int         n;
        bit         id;
        kind = $urandom_range(0, 99);
        id   = ($urandom_range(0, 9) != 0);
        if (kind < 10 || qry_len > 48)
        begin
            n = $urandom_range(0, 24);
            repeat (n) bytes = {bytes, rand_column_byte()};
            if (bytes.size() == 0 || $urandom_range(0, 3) == 0)
                bytes = {bytes, rand_lower()};
            send_row(CMD_QUERY, id, bytes);
        end
        else if (kind < 88)
        begin
            n = (kind < 75) ? qry_len : $urandom_range(0, qry_len + 4);
            for (int j = 0; j < n; j++)
            begin
                if ($urandom_range(0, 9) == 0)
                    bytes = {bytes, rand_lower()};
                bytes = {bytes, candidate_byte(j)};
            end
            if (bytes.size() == 0 || $urandom_range(0, 4) == 0)
                bytes = {bytes, rand_lower()};
            send_row(CMD_CAND, id, bytes);
        end
        else if (kind < 94)
        begin
            n = $urandom_range(1, 12);
            for (int j = 0; j < n; j++)
            begin
                it.cmd     = 1'($urandom_range(0, 1));
                it.ch      = ($urandom_range(0, 5) == 0) ? rand_lower() : candidate_byte(j);
                it.row_end = (j == n - 1);
                it.has_id  = id;
                send_item(it);
            end
        end
        else
        begin
            n = $urandom_range(1, 6);
            repeat (n)
            begin
                it.cmd     = 1'($urandom_range(0, 1));
                it.ch      = 8'($urandom_range(0, 255));
                it.row_end = ($urandom_range(0, 2) == 0);
                it.has_id  = 1'($urandom_range(0, 1));
                send_item(it);
            end
        end
    endtask

    task automatic test_empty_query();
        byte_q_t bytes;
        bytes = '{8'h41, 8'h42};
        send_row(CMD_CAND, 1'b1, bytes);
        bytes = '{8'h78, 8'h79};
        send_row(CMD_QUERY, 1'b1, bytes);
        bytes = '{8'h71};
        send_row(CMD_CAND, 1'b1, bytes);
        bytes = '{arcf_pkg::GAP_CHAR};
        send_row(CMD_CAND, 1'b1, bytes);
    endtask

    task automatic test_long_rows();
        byte_q_t qbytes;
        repeat (LONG_COLS) qbytes = {qbytes, rand_column_byte()};
        send_row(CMD_QUERY, 1'b0, qbytes);
        send_row(CMD_CAND, 1'b1, qbytes);
        qbytes = {qbytes, 8'h41};
        send_row(CMD_CAND, 1'b1, qbytes);
    endtask

    task automatic test_directed_rows();
        byte_q_t    bytes;
        char_item_t it;
        bytes = '{8'h60, 8'hFF, arcf_pkg::GAP_CHAR, 8'h00, 8'h7B};
        send_row(CMD_QUERY, 1'b1, bytes);
        // exact copy with dropped letters, row closed by a dropped letter
        bytes = '{8'h60, 8'h7A, 8'hFF, arcf_pkg::GAP_CHAR, 8'h00, 8'h7B, 8'h61};
        send_row(CMD_CAND, 1'b1, bytes);
        bytes = '{8'h60, 8'hFF, arcf_pkg::GAP_CHAR, 8'h00, 8'h7B};
        send_row(CMD_CAND, 1'b0, bytes);
        bytes = '{8'h60, 8'hFF};
        send_row(CMD_CAND, 1'b1, bytes);
        // mixed row closed as a query
        it = '{cmd: CMD_CAND, ch: 8'h60, row_end: 1'b0, has_id: 1'b1};
        send_item(it);
        it = '{cmd: CMD_QUERY, ch: 8'h42, row_end: 1'b0, has_id: 1'b1};
        send_item(it);
        it = '{cmd: CMD_QUERY, ch: 8'h43, row_end: 1'b1, has_id: 1'b0};
        send_item(it);
    endtask

    task automatic test_threshold_extremes();
        byte_q_t bytes;
        set_thresholds(7'd0, 7'd0);
        bytes = '{arcf_pkg::GAP_CHAR, arcf_pkg::GAP_CHAR, arcf_pkg::GAP_CHAR};
        send_row(CMD_CAND, 1'b1, bytes);
        set_thresholds(7'd100, 7'd100);
        bytes = '{8'h60, 8'h42, 8'h43};
        send_row(CMD_CAND, 1'b1, bytes);
        bytes = '{8'h60, 8'h42, arcf_pkg::GAP_CHAR};
        send_row(CMD_CAND, 1'b1, bytes);
        set_thresholds(7'd127, 7'd0);
        bytes = '{8'h60, 8'h42, 8'h43};
        send_row(CMD_CAND, 1'b1, bytes);
        set_thresholds(7'd0, 7'd127);
        send_row(CMD_CAND, 1'b1, bytes);
        set_thresholds(arcf_pkg::MIN_COVERAGE_RST, arcf_pkg::MIN_IDENTITY_RST);
    endtask

    task automatic test_backpressure();
        int start;
        tx_idle_en = 1'b0;
        hold_requests++;
        start = chars_sent;
        while (chars_sent - start < 120)
            random_row();
        tx_idle_en = 1'b1;
        drain();
    endtask

    task automatic test_random_rows();
        int start;
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            case (p)
                0: set_thresholds(7'd0, 7'd0);
                1: set_thresholds(7'd100, 7'd100);
                2: set_thresholds(7'd127, 7'd127);
                default: set_thresholds(7'($urandom_range(0, 100)), 7'($urandom_range(0, 80)));
            endcase
            tx_idle_en = !(p == 3 || p == RANDOM_PHASES - 1);
            rx_idle_en = tx_idle_en;
            start = chars_sent;
            while (chars_sent - start < RANDOM_ITEMS / RANDOM_PHASES)
                random_row();
        end
    endtask

    // Receiver: random stall bursts, plus a long hold-off on request.
    always @(posedge clk)
    begin
        if (hold_served != hold_requests)
        begin
            hold_served = hold_requests;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            result_stall <= 1'b1;
        end
        else if (!rx_idle_en)
            result_stall <= 1'b0;
        else if (burst_left > 0)
        begin
            burst_left--;
            result_stall <= 1'b1;
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            burst_left = $urandom_range(0, 14);
            result_stall <= 1'b1;
        end
        else
            result_stall <= 1'b0;
    end

    task automatic check_field(input string name, input int unsigned exp_v, input int unsigned act_v);
        if (exp_v != act_v)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_verdicts.size() == 0)
            begin
                $error("row verdict with no pending row");
                errors++;
            end
            else
            begin
                want = expected_verdicts.pop_front();
                check_field("keep", want.keep, keep);
                check_field("row_is_query", want.row_is_query, row_is_query);
                check_field("gap_count", want.gaps, gap_count);
                check_field("match_count", want.hits, match_count);
                check_field("row_length", want.length, row_length);
                check_field("too_long", want.too_long, too_long);
                rows_checked++;
                rows_kept     += want.keep;
                rows_too_long += want.too_long;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((item_valid && !item_stall) || (result_valid && !result_stall))
            idle_cycles = 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
        else
            idle_cycles++;
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_query();
        test_long_rows();
        test_directed_rows();
        test_threshold_extremes();
        test_backpressure();
        test_random_rows();
        drain();
        $display("Sent %0d characters; checked %0d row verdicts (%0d kept, %0d too long).",
                 chars_sent, rows_checked, rows_kept, rows_too_long);
        $display("Covered empty, long and mixed rows, threshold extremes and backpressure.");
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
